// ----- src/rmws_pkg.sv -----
// Shared types and constants for the radio module watchdog sequencer.
// No dependencies; used by radio_module_watchdog_sequencer.
`default_nettype none

package rmws_pkg;

   // Command codes carried on each tick beat
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // Phase codes reported on the result channel
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_ON      = 2'd1;
   localparam logic [1:0] PHASE_OFF     = 2'd2;
   localparam logic [1:0] PHASE_RESTART = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SUBTICKS_PER_SECOND = 2'd0;
   localparam logic [1:0] CSR_STUCK_SECONDS       = 2'd1;
   localparam logic [1:0] CSR_SILENCE_MINUTES     = 2'd2;
   localparam logic [1:0] CSR_SETTLE_TICKS        = 2'd3;

   // Configuration reset values
   localparam logic [7:0] RST_SUBTICKS_PER_SECOND = 8'd50;
   localparam logic [7:0] RST_STUCK_SECONDS       = 8'd10;
   localparam logic [7:0] RST_SILENCE_MINUTES     = 8'd60;
   localparam logic [7:0] RST_SETTLE_TICKS        = 8'd5;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

   // Power sequencer state, one-hot
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ON      = 4'b0010,
      ST_OFF     = 4'b0100,
      ST_RESTART = 4'b1000
   } phase_state_type;

endpackage

`default_nettype wire

// ----- src/radio_module_watchdog_sequencer.sv -----
// Radio module watchdog and power sequencer: one tick beat in, one result beat out.
// An accepted request beat passes the input register, then the result register.
// Throughput: one beat per cycle unless rsp_ready stalls, set by the single update
// step of the counters and sequencer between the two registers.
// Reset: synchronous, active high; clears all counters, sequencer state and
// beat valid flags and loads the configuration registers with their defaults.
// Depends on rmws_pkg.
`default_nettype none

module radio_module_watchdog_sequencer (
   input  wire logic       clock,
   input  wire logic       reset,
   // tick request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_heartbeat_level,
   input  wire logic       req_data_received,
   input  wire logic [1:0] req_command,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_chip_enable,
   output logic            rsp_uart_enabled,
   output logic [1:0]      rsp_phase,
   output logic            rsp_restart_started,
   // configuration write port
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   // Configuration registers
   logic [7:0] cfg_sps_ff, cfg_stuck_ff, cfg_silence_ff, cfg_settle_ff;

   // Input stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_hb_ff, s1_rx_ff;
   logic [1:0] s1_cmd_ff;
   logic       s1_advance;

   // Watchdog counters
   logic [7:0] high_sub_ff, high_sub_in, high_sec_ff, high_sec_in;
   logic [7:0] low_sub_ff, low_sub_in, low_sec_ff, low_sec_in;
   logic [7:0] sil_sub_ff, sil_sub_in;
   logic [5:0] sil_sec_ff, sil_sec_in;
   logic [7:0] sil_min_ff, sil_min_in;

   // Power sequencer
   rmws_pkg::phase_state_type phase_ff, phase_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       pend_ff, pend_in;
   logic       enable_ff, enable_in;
   logic       uart_ff, uart_in;
   logic       fired;
   logic       done;
   logic [1:0] phase_code;

   // Result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ce_ff, rsp_uart_ff, rsp_fired_ff;
   logic [1:0] rsp_phase_ff;

   // Move the held beat on when the result slot is free or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 :
                         (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sps_ff     <= rmws_pkg::RST_SUBTICKS_PER_SECOND;
         cfg_stuck_ff   <= rmws_pkg::RST_STUCK_SECONDS;
         cfg_silence_ff <= rmws_pkg::RST_SILENCE_MINUTES;
         cfg_settle_ff  <= rmws_pkg::RST_SETTLE_TICKS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rmws_pkg::CSR_SUBTICKS_PER_SECOND: cfg_sps_ff     <= csr_write_data;
            rmws_pkg::CSR_STUCK_SECONDS:       cfg_stuck_ff   <= csr_write_data;
            rmws_pkg::CSR_SILENCE_MINUTES:     cfg_silence_ff <= csr_write_data;
            rmws_pkg::CSR_SETTLE_TICKS:        cfg_settle_ff  <= csr_write_data;
         endcase
      end
   end

   // One tick update: command, watchdogs, then sequencer
   always_comb begin
      fired       = 1'b0;
      done        = 1'b0;
      high_sub_in = high_sub_ff;
      high_sec_in = high_sec_ff;
      low_sub_in  = low_sub_ff;
      low_sec_in  = low_sec_ff;
      sil_sub_in  = sil_sub_ff;
      sil_sec_in  = sil_sec_ff;
      sil_min_in  = sil_min_ff;
      phase_in    = phase_ff;
      ticks_in    = ticks_ff;
      pend_in     = pend_ff;
      enable_in   = enable_ff;
      uart_in     = uart_ff;

      // take the command first; unused codes do nothing
      if (s1_cmd_ff == rmws_pkg::CMD_ON) begin
         phase_in = rmws_pkg::ST_ON;
         pend_in  = 1'b1;
      end else if (s1_cmd_ff == rmws_pkg::CMD_OFF) begin
         phase_in = rmws_pkg::ST_OFF;
      end

      // heartbeat stuck watchdog: count the current level, clear the other
      if (s1_hb_ff) begin
         low_sub_in  = 8'd0;
         low_sec_in  = 8'd0;
         high_sub_in = high_sub_ff + 8'd1;
         if (high_sub_in >= cfg_sps_ff) begin
            high_sub_in = 8'd0;
            high_sec_in = high_sec_ff + 8'd1;
            if (high_sec_in >= cfg_stuck_ff) begin
               high_sec_in = 8'd0;
               fired       = 1'b1;
            end
         end
      end else begin
         high_sub_in = 8'd0;
         high_sec_in = 8'd0;
         low_sub_in  = low_sub_ff + 8'd1;
         if (low_sub_in >= cfg_sps_ff) begin
            low_sub_in = 8'd0;
            low_sec_in = low_sec_ff + 8'd1;
            if (low_sec_in >= cfg_stuck_ff) begin
               low_sec_in = 8'd0;
               fired      = 1'b1;
            end
         end
      end

      // silence watchdog: received data restarts the count at this tick
      if (s1_rx_ff) begin
         sil_sub_in = 8'd0;
         sil_sec_in = 6'd0;
         sil_min_in = 8'd0;
      end
      sil_sub_in = sil_sub_in + 8'd1;
      if (sil_sub_in >= cfg_sps_ff) begin
         sil_sub_in = 8'd0;
         sil_sec_in = sil_sec_in + 6'd1;
         if (sil_sec_in >= rmws_pkg::SECONDS_PER_MINUTE) begin
            sil_sec_in = 6'd0;
            sil_min_in = sil_min_in + 8'd1;
            if (sil_min_in >= cfg_silence_ff) begin
               sil_min_in = 8'd0;
               fired      = 1'b1;
            end
         end
      end

      // a watchdog overrides the command
      if (fired) begin
         phase_in = rmws_pkg::ST_RESTART;
         pend_in  = 1'b1;
      end

      // power sequencer
      unique case (phase_in)
         rmws_pkg::ST_ON: begin
            if (pend_in) begin
               pend_in   = 1'b0;
               ticks_in  = 8'd0;
               enable_in = 1'b1;
            end
            done     = ticks_in >= cfg_settle_ff;
            ticks_in = done ? 8'd0 : ticks_in + 8'd1;
            if (done) begin
               phase_in = rmws_pkg::ST_IDLE;
               uart_in  = 1'b1;
            end
         end
         rmws_pkg::ST_OFF: begin
            pend_in   = 1'b0;
            ticks_in  = 8'd0;
            enable_in = 1'b0;
            uart_in   = 1'b0;
            phase_in  = rmws_pkg::ST_IDLE;
         end
         rmws_pkg::ST_RESTART: begin
            if (pend_in) begin
               pend_in   = 1'b0;
               ticks_in  = 8'd0;
               enable_in = 1'b0;
               uart_in   = 1'b0;
            end
            done     = ticks_in >= cfg_settle_ff;
            ticks_in = done ? 8'd0 : ticks_in + 8'd1;
            if (done) begin
               phase_in = rmws_pkg::ST_ON;
               pend_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // map the state to its reported code
      unique case (phase_in)
         rmws_pkg::ST_ON:      phase_code = rmws_pkg::PHASE_ON;
         rmws_pkg::ST_OFF:     phase_code = rmws_pkg::PHASE_OFF;
         rmws_pkg::ST_RESTART: phase_code = rmws_pkg::PHASE_RESTART;
         default:              phase_code = rmws_pkg::PHASE_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         high_sub_ff  <= 8'd0;
         high_sec_ff  <= 8'd0;
         low_sub_ff   <= 8'd0;
         low_sec_ff   <= 8'd0;
         sil_sub_ff   <= 8'd0;
         sil_sec_ff   <= 6'd0;
         sil_min_ff   <= 8'd0;
         phase_ff     <= rmws_pkg::ST_IDLE;
         ticks_ff     <= 8'd0;
         pend_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         uart_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance state only as a beat leaves the input register
         if (s1_advance) begin
            high_sub_ff <= high_sub_in;
            high_sec_ff <= high_sec_in;
            low_sub_ff  <= low_sub_in;
            low_sec_ff  <= low_sec_in;
            sil_sub_ff  <= sil_sub_in;
            sil_sec_ff  <= sil_sec_in;
            sil_min_ff  <= sil_min_in;
            phase_ff    <= phase_in;
            ticks_ff    <= ticks_in;
            pend_ff     <= pend_in;
            enable_ff   <= enable_in;
            uart_ff     <= uart_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_hb_ff  <= req_heartbeat_level;
         s1_rx_ff  <= req_data_received;
         s1_cmd_ff <= req_command;
      end
      if (s1_advance) begin
         rsp_ce_ff    <= enable_in;
         rsp_uart_ff  <= uart_in;
         rsp_phase_ff <= phase_code;
         rsp_fired_ff <= fired;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chip_enable     = rsp_ce_ff;
   assign rsp_uart_enabled    = rsp_uart_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_restart_started = rsp_fired_ff;

   // Power-off always completes within its tick
   a_no_off_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase != rmws_pkg::PHASE_OFF)
      else $error("powering-off phase reported on a result beat");

   // A fired watchdog leaves the sequencer restarting or already powering on
   a_fire_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restart_started) |->
         (rsp_phase == rmws_pkg::PHASE_RESTART || rsp_phase == rmws_pkg::PHASE_ON))
      else $error("watchdog fired without entering restart");

   // The UART is only on while the module is powered
   a_uart_needs_ce: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_uart_enabled) |-> rsp_chip_enable)
      else $error("UART enabled with chip enable low");

   // A held beat with a free result slot moves on in the next cycle
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("held beat failed to reach the result register");

endmodule

`default_nettype wire
